/* rtl/button_press_event_classifier_assert.svh */
`ifndef BUTTON_PRESS_EVENT_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_EVENT_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BPEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define BPEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bpec_pkg.sv */
package bpec_pkg;

  localparam int COUNT_WIDTH_DEF = 13;
  localparam int CFG_DATA_W      = 12;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd2;
  localparam logic [11:0] LONG_RST     = 12'd20;
  localparam logic [7:0]  REPEAT_RST   = 8'd6;
  localparam logic [7:0]  WINDOW_RST   = 8'd6;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW   = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DOWN  = 2'd1;
  localparam logic [1:0] PH_PRESS = 2'd2;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_DOWN   = 3'd1;
  localparam logic [2:0] EV_START  = 3'd2;
  localparam logic [2:0] EV_REPEAT = 3'd3;
  localparam logic [2:0] EV_SHORT  = 3'd4;
  localparam logic [2:0] EV_LONG   = 3'd5;

  typedef struct packed {
    logic [2:0] event_code;
    logic       single_click;
    logic       double_click;
    logic       hold_active;
  } result_t;

endpackage

/* rtl/button_press_event_classifier.sv */
// Button event classifier: takes one sampled button level per beat and returns one result
// beat per input beat (event code, click pulses, hold flag), registered once the input is
// accepted. All state updates are a single pass of counters and compares, so one beat is
// accepted every cycle while in_stall is low. The output side has a result register plus a
// one-entry skid register; in_stall rises the cycle after a beat is taken while the result
// register is held by out_stall, and falls once the skid entry has moved up. Configuration
// writes take effect at the next clock edge.
module button_press_event_classifier #(
  parameter int COUNT_WIDTH = bpec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpec_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             button_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       event_code,
  output logic                             single_click,
  output logic                             double_click,
  output logic                             hold_active
);

  logic [7:0]  debounce_ticks;
  logic [11:0] long_ticks;
  logic [7:0]  repeat_ticks;
  logic [7:0]  double_window;

  logic                   previous_level;
  logic [COUNT_WIDTH-1:0] hold_count, hold_count_next;
  logic [1:0]             press_phase, press_phase_next;
  logic [7:0]             repeat_phase, repeat_phase_next;
  logic [7:0]             double_count, double_count_next;
  logic                   hold_flag, hold_flag_next;

  logic [COUNT_WIDTH-1:0] deb_ext, long_ext;
  logic [7:0]             rep_inc;
  logic [2:0]             ev;
  logic                   single_next, double_next;

  bpec_pkg::result_t res_next, out_res, skid_res;
  logic              skid_valid;
  logic              accept_in, out_take;

  assign deb_ext  = COUNT_WIDTH'(debounce_ticks);
  assign long_ext = COUNT_WIDTH'(long_ticks);
  assign rep_inc  = repeat_phase + 8'd1;

  assign in_stall  = skid_valid;
  assign accept_in = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    hold_count_next   = hold_count;
    press_phase_next  = press_phase;
    repeat_phase_next = repeat_phase;
    double_count_next = double_count;
    hold_flag_next    = hold_flag;
    ev                = bpec_pkg::EV_NONE;
    single_next       = 1'b0;
    double_next       = 1'b0;

    if (button_level) begin
      if (!previous_level) begin
        hold_count_next  = '0;
        press_phase_next = bpec_pkg::PH_DOWN;
      end else if (hold_count != '1) begin
        hold_count_next = hold_count + COUNT_WIDTH'(1);
      end
      if (press_phase_next == bpec_pkg::PH_DOWN) begin
        if (hold_count_next == deb_ext) begin
          ev = bpec_pkg::EV_DOWN;
        end else if (hold_count_next == long_ext) begin
          press_phase_next  = bpec_pkg::PH_PRESS;
          repeat_phase_next = 8'd0;
          ev                = bpec_pkg::EV_START;
        end
      end else if (press_phase_next == bpec_pkg::PH_PRESS) begin
        repeat_phase_next = rep_inc;
        if (rep_inc == repeat_ticks) begin
          repeat_phase_next = 8'd0;
          ev                = bpec_pkg::EV_REPEAT;
        end
      end
    end else begin
      hold_flag_next = 1'b0;
      if (hold_count > long_ext) begin
        ev = bpec_pkg::EV_LONG;
      end else if (hold_count > deb_ext) begin
        ev = bpec_pkg::EV_SHORT;
      end
      if (double_count != 8'd0) begin
        double_count_next = double_count - 8'd1;
      end
      hold_count_next  = '0;
      press_phase_next = bpec_pkg::PH_IDLE;
    end

    if (!hold_flag_next) begin
      if (ev == bpec_pkg::EV_DOWN) begin
        if (double_count_next != 8'd0) begin
          double_count_next = 8'd0;
          double_next       = 1'b1;
        end else begin
          single_next = 1'b1;
        end
      end else if (ev == bpec_pkg::EV_SHORT) begin
        double_count_next = double_window;
      end else if (ev == bpec_pkg::EV_START) begin
        hold_flag_next = 1'b1;
      end
    end

    res_next.event_code   = ev;
    res_next.single_click = single_next;
    res_next.double_click = double_next;
    res_next.hold_active  = hold_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= bpec_pkg::DEBOUNCE_RST;
      long_ticks     <= bpec_pkg::LONG_RST;
      repeat_ticks   <= bpec_pkg::REPEAT_RST;
      double_window  <= bpec_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpec_pkg::REG_DEBOUNCE: debounce_ticks <= cfg_data[7:0];
        bpec_pkg::REG_LONG:     long_ticks     <= cfg_data[11:0];
        bpec_pkg::REG_REPEAT:   repeat_ticks   <= cfg_data[7:0];
        bpec_pkg::REG_WINDOW:   double_window  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      hold_count     <= '0;
      press_phase    <= bpec_pkg::PH_IDLE;
      repeat_phase   <= 8'd0;
      double_count   <= 8'd0;
      hold_flag      <= 1'b0;
    end else if (accept_in) begin
      previous_level <= button_level;
      hold_count     <= hold_count_next;
      press_phase    <= press_phase_next;
      repeat_phase   <= repeat_phase_next;
      double_count   <= double_count_next;
      hold_flag      <= hold_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept_in) begin
        out_res <= res_next;
      end
    end else if (accept_in) begin
      skid_res <= res_next;
    end
  end

  assign event_code   = out_res.event_code;
  assign single_click = out_res.single_click;
  assign double_click = out_res.double_click;
  assign hold_active  = out_res.hold_active;

endmodule

/* rtl/bpec_checker.sv */
`include "button_press_event_classifier_assert.svh"

module bpec_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] event_code,
  input logic       single_click,
  input logic       double_click,
  input logic       hold_active
);

  `BPEC_ASSERT_NOW(a_click_exclusive, out_valid, !(single_click && double_click), "both click pulses set")
  `BPEC_ASSERT_NOW(a_click_on_down, out_valid && (single_click || double_click), event_code == bpec_pkg::EV_DOWN, "click pulse without down event")
  `BPEC_ASSERT_NOW(a_release_clears_hold, out_valid && (event_code == bpec_pkg::EV_SHORT || event_code == bpec_pkg::EV_LONG), !hold_active, "hold flag set on release beat")
  `BPEC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_code) && $stable(hold_active), "stalled result beat changed")

endmodule

bind button_press_event_classifier bpec_checker u_bpec_checker (.*);

/* test/button_press_event_classifier_check.sv */
module button_press_event_classifier_check #(
  parameter int COUNT_WIDTH = bpec_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpec_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             button_level,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [2:0]                       event_code,
  input  logic                             single_click,
  input  logic                             double_click,
  input  logic                             hold_active,
  output int                               mismatches,
  output int                               results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [7:0]             debounce_ticks;
  logic [11:0]            long_ticks;
  logic [7:0]             repeat_ticks;
  logic [7:0]             double_window;
  logic                   prev_level;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic [1:0]             press_phase;
  logic [7:0]             repeat_phase;
  logic [7:0]             double_count;
  logic                   hold_flag;
  bpec_pkg::result_t      due_results[$];
  int                     miss_count;

  function automatic bpec_pkg::result_t classify_tick(input logic level);
    bpec_pkg::result_t r;
    logic [2:0]        ev;
    r = '0;
    ev = bpec_pkg::EV_NONE;
    if (level) begin
      if (!prev_level) begin
        hold_count = '0;
        press_phase = bpec_pkg::PH_DOWN;
      end else if (hold_count != COUNT_MAX) begin
        hold_count = hold_count + 1'b1;
      end
      if (press_phase == bpec_pkg::PH_DOWN) begin
        if (hold_count == debounce_ticks) begin
          ev = bpec_pkg::EV_DOWN;
        end else if (hold_count == long_ticks) begin
          press_phase = bpec_pkg::PH_PRESS;
          repeat_phase = '0;
          ev = bpec_pkg::EV_START;
        end
      end else if (press_phase == bpec_pkg::PH_PRESS) begin
        repeat_phase = repeat_phase + 8'd1;
        if (repeat_phase == repeat_ticks) begin
          repeat_phase = '0;
          ev = bpec_pkg::EV_REPEAT;
        end
      end
    end else begin
      hold_flag = 1'b0;
      if (hold_count > long_ticks) ev = bpec_pkg::EV_LONG;
      else if (hold_count > debounce_ticks) ev = bpec_pkg::EV_SHORT;
      if (double_count != 8'd0) double_count = double_count - 8'd1;
      hold_count = '0;
      press_phase = bpec_pkg::PH_IDLE;
    end
    prev_level = level;
    if (ev != bpec_pkg::EV_NONE && !hold_flag) begin
      case (ev)
        bpec_pkg::EV_DOWN: begin
          if (double_count != 8'd0) begin
            double_count = '0;
            r.double_click = 1'b1;
          end else begin
            r.single_click = 1'b1;
          end
        end
        bpec_pkg::EV_SHORT: double_count = double_window;
        bpec_pkg::EV_START: hold_flag = 1'b1;
        default: ;
      endcase
    end
    r.event_code = ev;
    r.hold_active = hold_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    bpec_pkg::result_t seen;
    bpec_pkg::result_t want;
    if (rst) begin
      debounce_ticks = bpec_pkg::DEBOUNCE_RST;
      long_ticks = bpec_pkg::LONG_RST;
      repeat_ticks = bpec_pkg::REPEAT_RST;
      double_window = bpec_pkg::WINDOW_RST;
      prev_level = 1'b0;
      hold_count = '0;
      press_phase = bpec_pkg::PH_IDLE;
      repeat_phase = '0;
      double_count = '0;
      hold_flag = 1'b0;
      due_results.delete();
      miss_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpec_pkg::REG_DEBOUNCE: debounce_ticks = cfg_data[7:0];
          bpec_pkg::REG_LONG: long_ticks = cfg_data[11:0];
          bpec_pkg::REG_REPEAT: repeat_ticks = cfg_data[7:0];
          bpec_pkg::REG_WINDOW: double_window = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen = {event_code, single_click, double_click, hold_active};
        if (due_results.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("unexpected result beat: event %0d single %0b double %0b hold %0b",
                     seen.event_code, seen.single_click, seen.double_click,
                     seen.hold_active);
        end else begin
          want = due_results.pop_front();
          if (seen.event_code !== want.event_code ||
              seen.single_click !== want.single_click ||
              seen.double_click !== want.double_click ||
              seen.hold_active !== want.hold_active) begin
            miss_count++;
            if (miss_count <= 10)
              $display({"mismatch: expected event %0d single %0b double %0b hold %0b,",
                        " got event %0d single %0b double %0b hold %0b"},
                       want.event_code, want.single_click, want.double_click,
                       want.hold_active, seen.event_code, seen.single_click,
                       seen.double_click, seen.hold_active);
          end
        end
      end
      if (in_valid && !in_stall) due_results.push_back(classify_tick(button_level));
    end
    mismatches <= miss_count;
    results_due <= due_results.size();
  end

endmodule

/* test/button_press_event_classifier_test.sv */
module button_press_event_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [bpec_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bpec_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             button_level = 1'b0;
  logic                             out_stall = 1'b0;
  logic                             in_stall;
  logic                             out_valid;
  logic [2:0]                       event_code;
  logic                             single_click;
  logic                             double_click;
  logic                             hold_active;
  int                               mismatches;
  int                               results_due;
  int                               send_idle_pct = 0;
  int                               stall_pct = 0;
  int                               ticks_sent = 0;
  int                               cycles = 0;
  int                               deb_now = bpec_pkg::DEBOUNCE_RST;
  int                               long_now = bpec_pkg::LONG_RST;
  int                               rep_now = bpec_pkg::REPEAT_RST;
  int                               win_now = bpec_pkg::WINDOW_RST;

  button_press_event_classifier dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .button_level(button_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_code(event_code), .single_click(single_click),
    .double_click(double_click), .hold_active(hold_active)
  );

  button_press_event_classifier_check event_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .button_level(button_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_code(event_code), .single_click(single_click),
    .double_click(double_click), .hold_active(hold_active),
    .mismatches(mismatches), .results_due(results_due)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_tick(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    button_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic press(input int high_ticks, input int low_ticks);
    repeat (high_ticks) send_tick(1'b1);
    repeat (low_ticks) send_tick(1'b0);
  endtask

  task automatic set_regs(input int deb, input int lng, input int rep, input int win);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= bpec_pkg::REG_DEBOUNCE;
    cfg_data <= bpec_pkg::CFG_DATA_W'(deb);
    @(posedge clk);
    cfg_index <= bpec_pkg::REG_LONG;
    cfg_data <= bpec_pkg::CFG_DATA_W'(lng);
    @(posedge clk);
    cfg_index <= bpec_pkg::REG_REPEAT;
    cfg_data <= bpec_pkg::CFG_DATA_W'(rep);
    @(posedge clk);
    cfg_index <= bpec_pkg::REG_WINDOW;
    cfg_data <= bpec_pkg::CFG_DATA_W'(win);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    deb_now = deb;
    long_now = lng;
    rep_now = rep;
    win_now = win;
  endtask

  task automatic set_mode(input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct = stall;
  endtask

  task automatic random_presses(input int budget);
    int  start;
    int  n;
    int  m;
    int  rep_span;
    bit  paused;
    start = ticks_sent;
    paused = 1'b0;
    while (ticks_sent - start < budget) begin
      if ($urandom_range(7) == 0) begin
        send_tick($urandom_range(1));
      end else begin
        rep_span = (rep_now == 0) ? 256 : rep_now;
        case ($urandom_range(3))
          0: n = $urandom_range(deb_now + 2, 1);
          1: n = $urandom_range(long_now + 2, (long_now > 1) ? long_now - 1 : 1);
          2: n = long_now + $urandom_range(3 * rep_span + 2, 1);
          default: n = $urandom_range(8, 1);
        endcase
        if (n > 40) n = 40;
        m = $urandom_range((win_now + 2 > 20) ? 20 : win_now + 2, 1);
        press(n, m);
      end
      // sender holds off until the block has drained
      if ((!paused && ticks_sent - start >= budget / 2) || $urandom_range(19) == 0) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_mode(0, 0);
    send_tick(1'b0);
    press(4, 1);
    press(3, 1);
    press(4, 8);
    press(3, 1);
    random_presses(45);

    set_regs(3, 12, 3, 8);
    set_mode(85, 0);
    random_presses(45);

    // down and press start on the same count, window of zero
    set_regs(5, 5, 1, 0);
    set_mode(0, 85);
    random_presses(45);

    // press start ahead of down
    set_regs(10, 3, 255, 255);
    set_mode(33, 33);
    random_presses(45);

    // press start on the first high tick, repeat period of zero
    set_regs(255, 0, 0, 1);
    set_mode(85, 0);
    random_presses(45);

    set_regs(1, 2, 1, 1);
    set_mode(0, 85);
    random_presses(45);

    // down on the first high tick, long press out of reach
    set_regs(0, 4095, 0, 255);
    set_mode(33, 33);
    random_presses(45);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
